// File: sv/csr_sparse_matvec_defines.svh
// assertion macros for the sparse matrix-vector block
`ifndef CSR_SPARSE_MATVEC_DEFINES_SVH
`define CSR_SPARSE_MATVEC_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define CSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define CSM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CSM_ASSERT(name, prop, msg)
`define CSM_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: sv/csm_pkg.sv
package csm_pkg;

  localparam int VEC_DEPTH = 1024;
  localparam int VEC_AW    = $clog2(VEC_DEPTH);
  localparam int MAX_ROWS  = 65536;
  localparam int ROW_CW    = $clog2(MAX_ROWS);

  localparam int OPW   = 2;
  localparam int IDXW  = 10;
  localparam int VALW  = 32;
  localparam int ROWW  = 16;
  localparam int SUMW  = 64;
  localparam int VLENW = 11;

  localparam logic [VLENW-1:0] VLEN_RESET = VLENW'(1024);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef enum logic [OPW-1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_EMPTY = 2'd2
  } op_e;

  // item handed from the accept stage to the multiply-accumulate pipe
  typedef struct packed {
    logic                   valid;
    logic [OPW-1:0]         op;
    logic signed [VALW-1:0] value;
    logic                   row_end;
    logic                   in_range;
  } csm_issue_t;

  // occupancy of the multiply-accumulate pipe
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } csm_pipe_t;

  typedef struct packed {
    logic [ROWW-1:0]        row_index;
    logic signed [SUMW-1:0] row_sum;
    logic                   index_error;
  } csm_result_t;

  function automatic logic signed [SUMW-1:0] sat_add(input logic signed [SUMW-1:0] a,
                                                     input logic signed [SUMW-1:0] b);
    logic signed [SUMW-1:0] s;
    s = a + b;
    if ((a[SUMW-1] == b[SUMW-1]) && (s[SUMW-1] != a[SUMW-1])) begin
      s = a[SUMW-1] ? {1'b1, {(SUMW-1){1'b0}}} : {1'b0, {(SUMW-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// File: sv/csm_ifs.sv
interface csm_in_if import csm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [OPW-1:0]         operation;
  logic [IDXW-1:0]        index;
  logic signed [VALW-1:0] value;
  logic                   row_end;

  modport source (output valid, output operation, output index, output value,
                  output row_end, input ready);
  modport sink (input valid, input operation, input index, input value,
                input row_end, output ready);
endinterface

interface csm_out_if import csm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [ROWW-1:0]        row_index;
  logic signed [SUMW-1:0] row_sum;
  logic                   index_error;

  modport source (output valid, output row_index, output row_sum, output index_error,
                  input ready);
  modport sink (input valid, input row_index, input row_sum, input index_error,
                output ready);
endinterface

// File: sv/csm_vec_ram.sv
module csm_vec_ram import csm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [VEC_AW-1:0]      waddr_i,
  input  logic signed [VALW-1:0] wdata_i,
  input  logic [VEC_AW-1:0]      raddr_i,
  output logic signed [VALW-1:0] rdata_o
);

  logic signed [VALW-1:0] mem [VEC_DEPTH];
  logic signed [VALW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/csm_mac.sv
module csm_mac import csm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csm_issue_t             issue_i,
  input  logic signed [VALW-1:0] vec_data_i,
  output csm_pipe_t              pipe_o,
  output logic                   push_o,
  output csm_result_t            result_o
);

  csm_issue_t             s1_q;
  logic                   s2_valid_q;
  logic [OPW-1:0]         s2_op_q;
  logic                   s2_row_end_q;
  logic                   s2_in_range_q;
  logic signed [SUMW-1:0] s2_prod_q;

  logic signed [SUMW-1:0] acc_q, acc_d, sum;
  logic                   err_q, err_d, err_now;
  logic [ROW_CW-1:0]      row_cnt_q, row_cnt_d;
  logic                   is_mac, emit;

  // stage 1: vector entry arrives from the ram, multiply
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_q       <= issue_i;
      s2_valid_q <= s1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q       <= s1_q.op;
    s2_row_end_q  <= s1_q.row_end;
    s2_in_range_q <= s1_q.in_range;
    s2_prod_q     <= SUMW'(s1_q.value) * SUMW'(vec_data_i);
  end

  // stage 2: accumulate and close the row
  always_comb begin
    is_mac    = s2_valid_q && (s2_op_q == OP_MAC);
    sum       = (is_mac && s2_in_range_q) ? sat_add(acc_q, s2_prod_q) : acc_q;
    err_now   = err_q | (is_mac & ~s2_in_range_q);
    emit      = (is_mac && s2_row_end_q) || (s2_valid_q && (s2_op_q == OP_EMPTY));
    acc_d     = sum;
    err_d     = err_now;
    row_cnt_d = row_cnt_q;
    if (emit) begin
      acc_d     = '0;
      err_d     = 1'b0;
      row_cnt_d = (row_cnt_q == ROW_CW'(MAX_ROWS - 1)) ? '0 : row_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      err_q     <= 1'b0;
      row_cnt_q <= '0;
    end else begin
      acc_q     <= acc_d;
      err_q     <= err_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  assign push_o               = emit;
  assign result_o.row_index   = ROWW'(row_cnt_q);
  assign result_o.row_sum     = sum;
  assign result_o.index_error = err_now;
  assign pipe_o.s1_valid      = s1_q.valid;
  assign pipe_o.s2_valid      = s2_valid_q;

endmodule

// File: sv/csm_out_fifo.sv
module csm_out_fifo import csm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  csm_result_t        data_i,
  output logic [FIFO_CW-1:0] count_o,
  csm_out_if.source          out_if
);

  csm_result_t        mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               pop;
  csm_result_t        head;

  assign pop  = out_if.valid && out_if.ready;
  assign head = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign out_if.valid       = (count_q != '0);
  assign out_if.row_index   = head.row_index;
  assign out_if.row_sum     = head.row_sum;
  assign out_if.index_error = head.index_error;
  assign count_o            = count_q;

endmodule

// File: sv/csr_sparse_matvec.sv
// channel   dir  fields                              transfer
// in_if     in   operation, index, value, row_end    valid & ready
// out_if    out  row_index, row_sum, index_error     valid & ready
// cfg       in   cfg_wdata_i (vector_length)         cfg_we_i
//
// one item per cycle while in_if.ready is high; a row result enters the result
// queue after the closing transfer's ram read, multiply and accumulate steps
// the row accumulator is one register; each in-range MAC does one saturating add
// reset clears the pipe, row sum, row number and error flag; the vector ram
// is not cleared
// in_if stalls only when the 4-entry result queue plus items in the pipe fill it
`include "csr_sparse_matvec_defines.svh"

module csr_sparse_matvec import csm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VLENW-1:0] cfg_wdata_i,
  csm_in_if.sink           in_if,
  csm_out_if.source        out_if
);

  logic [VLENW-1:0]   vector_length_q;
  logic               in_xfer;
  logic               in_store, in_limit;
  csm_issue_t         issue;
  csm_pipe_t          pipe;
  logic signed [VALW-1:0] vec_data;
  logic               push;
  csm_result_t        result;
  logic [FIFO_CW-1:0] fifo_cnt;
  logic [FIFO_CW:0]   occupancy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q <= VLEN_RESET;
    end else if (cfg_we_i) begin
      vector_length_q <= cfg_wdata_i;
    end
  end

  // reserve a queue slot for every item still in the pipe
  assign occupancy = (FIFO_CW+1)'(fifo_cnt) + (FIFO_CW+1)'(pipe.s1_valid)
                   + (FIFO_CW+1)'(pipe.s2_valid);
  assign in_if.ready = occupancy < (FIFO_CW+1)'(FIFO_DEPTH);
  assign in_xfer     = in_if.valid && in_if.ready;

  assign in_store = 32'(in_if.index) < VEC_DEPTH;
  assign in_limit = in_store && (32'(in_if.index) < 32'(vector_length_q));

  always_comb begin
    issue.valid    = in_xfer;
    issue.op       = in_if.operation;
    issue.value    = in_if.value;
    issue.row_end  = in_if.row_end;
    issue.in_range = in_limit;
  end

  csm_vec_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && (in_if.operation == OP_LOAD) && in_store),
    .waddr_i (VEC_AW'(in_if.index)),
    .wdata_i (in_if.value),
    .raddr_i (VEC_AW'(in_if.index)),
    .rdata_o (vec_data)
  );

  csm_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (issue),
    .vec_data_i (vec_data),
    .pipe_o     (pipe),
    .push_o     (push),
    .result_o   (result)
  );

  csm_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .count_o (fifo_cnt),
    .out_if  (out_if)
  );

  `CSM_ASSERT(a_credit_bound, occupancy <= (FIFO_CW+1)'(FIFO_DEPTH), "result queue over-committed")
  `CSM_ASSERT(a_no_overflow, push |-> (fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || out_if.ready, "push into full queue")
  `CSM_ASSERT(a_empty_row_emits, (in_xfer && (in_if.operation == OP_EMPTY)) |-> ##2 push, "empty row gave no result")
  `CSM_ASSERT(a_load_no_push, (pipe.s2_valid && !push) |-> (fifo_cnt == $past(fifo_cnt) || $past(out_if.valid && out_if.ready) || $past(push)), "queue count moved without transfer")

endmodule
